[src/bale_pkg.sv]
// ----------------------------------------------------------------------------
// bale_pkg
// Types and codes shared by the bounded array list blocks.
// ----------------------------------------------------------------------------
package bale_pkg;

  localparam int unsigned OpcodeW = 3;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned PosW    = 4;
  localparam int unsigned CountW  = 5;

  typedef enum logic [OpcodeW-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_POP_BACK   = 3'd1,
    OP_PUSH_FRONT = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_INSERT     = 3'd4,
    OP_ERASE      = 3'd5,
    OP_READ       = 3'd6,
    OP_WRITE      = 3'd7
  } op_e;

  typedef struct packed {
    logic [OpcodeW-1:0]       opcode;
    logic signed [ValueW-1:0] value;
    logic [PosW-1:0]          position;
  } in_t;

  typedef struct packed {
    logic signed [ValueW-1:0] read_value;
    logic [CountW-1:0]        count;
    logic                     is_empty;
    logic                     is_full;
    logic [CountW-1:0]        free_space;
    logic                     error;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

endpackage

[src/bale_ctrl.sv]
// ----------------------------------------------------------------------------
// bale_ctrl
// Handshake controller: loads one item, executes it when the result
// register is free, and holds the result until it is taken.
// ----------------------------------------------------------------------------
module bale_ctrl import bale_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_vld_q, out_vld_d;

  always_comb begin
    state_d         = state_q;
    cmd_o.load      = 1'b0;
    cmd_o.exec      = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_vld_q || out_ready_i) begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_o.exec) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_vld_q;

endmodule

[src/bale_dpath.sv]
// ----------------------------------------------------------------------------
// bale_dpath
// Item register, register cells with parallel shift, element count and
// result register.
// ----------------------------------------------------------------------------
module bale_dpath import bale_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  in_t  in_data_i,
  output out_t out_data_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = (CntW > PosW) ? CntW : PosW;

  in_t              item_q;
  logic [WIDTH-1:0] cells_q [DEPTH];
  logic [WIDTH-1:0] cells_d [DEPTH];
  logic [CntW-1:0]  held_q, held_d;
  out_t             res_q, res_d;

  logic [CmpW-1:0]  held_c, pos_c, ins_p, del_p;
  logic             full, empty;
  logic             do_ins, do_del, do_pop, do_wr, do_rd, err;
  logic [WIDTH-1:0] wr_val, rd_sel;
  logic [ValueW-1:0] rd_ext;

  assign held_c = CmpW'(held_q);
  assign pos_c  = CmpW'(item_q.position);
  assign full   = (held_q == CntW'(DEPTH));
  assign empty  = (held_q == '0);
  assign wr_val = WIDTH'($unsigned(item_q.value));

  always_comb begin
    do_ins = 1'b0;
    do_del = 1'b0;
    do_pop = 1'b0;
    do_wr  = 1'b0;
    do_rd  = 1'b0;
    err    = 1'b0;
    ins_p  = '0;
    del_p  = '0;
    unique case (op_e'(item_q.opcode))
      OP_PUSH_BACK: begin
        err    = full;
        ins_p  = held_c;
        do_ins = !full;
      end
      OP_POP_BACK: begin
        err    = empty;
        do_pop = !empty;
      end
      OP_PUSH_FRONT: begin
        err    = full;
        do_ins = !full;
      end
      OP_POP_FRONT: begin
        err    = empty;
        do_del = !empty;
      end
      OP_INSERT: begin
        err    = full || (pos_c > held_c);
        ins_p  = pos_c;
        do_ins = !err;
      end
      OP_ERASE: begin
        err    = (pos_c >= held_c);
        del_p  = pos_c;
        do_del = !err;
      end
      OP_READ: begin
        err   = (pos_c >= held_c);
        do_rd = !err;
      end
      OP_WRITE: begin
        err   = (pos_c >= held_c);
        do_wr = !err;
      end
    endcase
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    always_comb begin
      cells_d[g] = cells_q[g];
      if (do_ins) begin
        if (CmpW'(g) == ins_p) begin
          cells_d[g] = wr_val;
        end else if (CmpW'(g) > ins_p) begin
          if (g > 0) begin
            cells_d[g] = cells_q[(g > 0) ? g - 1 : 0];
          end
        end
      end else if (do_del) begin
        if ((CmpW'(g) >= del_p) && (g < DEPTH - 1)) begin
          cells_d[g] = cells_q[(g < DEPTH - 1) ? g + 1 : g];
        end
      end else if (do_wr && (CmpW'(g) == pos_c)) begin
        cells_d[g] = wr_val;
      end
    end
  end

  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (CmpW'(i) == pos_c) begin
        rd_sel = cells_q[i];
      end
    end
  end

  if (WIDTH >= ValueW) begin : g_rd_trunc
    assign rd_ext = rd_sel[ValueW-1:0];
  end else begin : g_rd_sext
    assign rd_ext = {{(ValueW - WIDTH){rd_sel[WIDTH-1]}}, rd_sel};
  end

  always_comb begin
    held_d = held_q;
    if (do_ins) begin
      held_d = held_q + CntW'(1);
    end else if (do_del || do_pop) begin
      held_d = held_q - CntW'(1);
    end
    res_d.read_value = do_rd ? $signed(rd_ext) : '0;
    res_d.count      = CountW'(held_d);
    res_d.is_empty   = (held_d == '0);
    res_d.is_full    = (held_d == CntW'(DEPTH));
    res_d.free_space = CountW'(CntW'(DEPTH) - held_d);
    res_d.error      = err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (cmd_i.exec) begin
      held_q <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
    if (cmd_i.exec) begin
      res_q <= res_d;
      for (int i = 0; i < DEPTH; i++) begin
        cells_q[i] <= cells_d[i];
      end
    end
  end

  assign out_data_o = res_q;

endmodule

[src/bounded_array_list_insert_erase.sv]
// ----------------------------------------------------------------------------
// bounded_array_list_insert_erase
// Fixed-capacity ordered list of signed words with push, pop, insert,
// erase, read and write at an index.
// ----------------------------------------------------------------------------
// One item is taken at a time: it is loaded into the item register, then
// executed over the DEPTH register cells (insert and erase shift all later
// cells at once) as soon as the result register is free or its result is
// being taken, and its result is shown in the cycle after execution. The
// next item is taken while a result still waits. Rejected operations set
// error and leave the list unchanged. Cells never written hold undefined data.
// ----------------------------------------------------------------------------
module bounded_array_list_insert_erase import bale_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  cmd_t cmd;

  bale_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  bale_dpath #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item taken while one is pending");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> ##1 out_valid_o)
    else $error("result missing two cycles after item");

  a_count_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (CountW'(out_data_o.count + out_data_o.free_space) == CountW'(DEPTH)))
    else $error("count and free space disagree");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.error |-> (out_data_o.read_value == '0))
    else $error("rejected item returned data");

endmodule

[bench/bale_list_checker.sv]
// ----------------------------------------------------------------------------
// bale_list_checker
// Watches both channels of the bounded array list, keeps its own copy of
// the list, predicts the result of every accepted item and compares each
// accepted result field by field, in order.
// ----------------------------------------------------------------------------
module bale_list_checker import bale_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  in_t  in_data_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  out_t out_data_i,
  output int   fail_count_o,
  output int   backlog_o,
  output int   checked_o,
  output int   rejected_o
);

  logic signed [ValueW-1:0] list_cells [DEPTH];
  int unsigned              list_len;
  out_t                     expected_q [$];
  out_t                     want;

  initial begin
    fail_count_o = 0;
    backlog_o    = 0;
    checked_o    = 0;
    rejected_o   = 0;
    list_len     = 0;
  end

  // open a gap at index at and store v there
  function automatic void list_place(int unsigned at, logic signed [ValueW-1:0] v);
    int unsigned j;
    for (j = list_len; j > at; j--) list_cells[j] = list_cells[j-1];
    list_cells[at] = v;
    list_len++;
  endfunction

  // close the gap at index at
  function automatic void list_remove(int unsigned at);
    int unsigned j;
    for (j = at; j + 1 < list_len; j++) list_cells[j] = list_cells[j+1];
    list_len--;
  endfunction

  function automatic out_t list_apply(in_t item);
    out_t        r;
    int unsigned p;
    logic        ok;
    r  = '0;
    p  = item.position;
    ok = 1'b1;
    case (op_e'(item.opcode))
      OP_PUSH_BACK: begin
        if (list_len >= DEPTH) ok = 1'b0;
        else list_place(list_len, item.value);
      end
      OP_POP_BACK: begin
        if (list_len == 0) ok = 1'b0;
        else list_len--;
      end
      OP_PUSH_FRONT: begin
        if (list_len >= DEPTH) ok = 1'b0;
        else list_place(0, item.value);
      end
      OP_POP_FRONT: begin
        if (list_len == 0) ok = 1'b0;
        else list_remove(0);
      end
      OP_INSERT: begin
        if (list_len >= DEPTH || p > list_len) ok = 1'b0;
        else list_place(p, item.value);
      end
      OP_ERASE: begin
        if (p >= list_len) ok = 1'b0;
        else list_remove(p);
      end
      OP_READ: begin
        if (p >= list_len) ok = 1'b0;
        else r.read_value = list_cells[p];
      end
      default: begin
        if (p >= list_len) ok = 1'b0;
        else list_cells[p] = item.value;
      end
    endcase
    r.count      = CountW'(list_len);
    r.is_empty   = (list_len == 0);
    r.is_full    = (list_len == DEPTH);
    r.free_space = CountW'(DEPTH - list_len);
    r.error      = !ok;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_len = 0;
      expected_q.delete();
      backlog_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) expected_q.push_back(list_apply(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("result with no item pending");
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          checked_o++;
          if (want.error) rejected_o++;
          if (out_data_i.read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value,
                   out_data_i.read_value);
            fail_count_o++;
          end
          if (out_data_i.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, out_data_i.count);
            fail_count_o++;
          end
          if (out_data_i.is_empty !== want.is_empty) begin
            $error("is_empty: expected %0d, got %0d", want.is_empty, out_data_i.is_empty);
            fail_count_o++;
          end
          if (out_data_i.is_full !== want.is_full) begin
            $error("is_full: expected %0d, got %0d", want.is_full, out_data_i.is_full);
            fail_count_o++;
          end
          if (out_data_i.free_space !== want.free_space) begin
            $error("free_space: expected %0d, got %0d", want.free_space,
                   out_data_i.free_space);
            fail_count_o++;
          end
          if (out_data_i.error !== want.error) begin
            $error("error: expected %0d, got %0d", want.error, out_data_i.error);
            fail_count_o++;
          end
        end
      end
      backlog_o = expected_q.size();
    end
  end

endmodule

[bench/tb_bounded_array_list_insert_erase.sv]
// ----------------------------------------------------------------------------
// tb_bounded_array_list_insert_erase
// Drives the bounded array list with a directed opening (empty and full
// rejections, value and index extremes) and then with random grow, shrink
// and mixed phases under random idling on both sides; a checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_bounded_array_list_insert_erase import bale_pkg::*;;

  localparam int unsigned LIST_DEPTH = 16;
  localparam int          RAND_ITEMS = 1025;
  localparam int          QUIET_TAIL = 150;
  localparam int          DRAIN_AT   = 400;
  localparam int          LONG_AT    = 500;
  localparam int          LONG_HOLD  = 60;
  localparam int          TAIL_WAIT  = 8;
  localparam int          LIMIT      = 100000;

  typedef enum int {GROW, SHRINK, MIX} mix_e;

  logic clk_i     = 1'b0;
  logic rst_ni    = 1'b0;
  logic in_valid  = 1'b0;
  logic out_ready = 1'b0;
  in_t  in_data   = '0;
  logic in_ready;
  logic out_valid;
  out_t out_data;

  int   fail_count;
  int   backlog;
  int   checked;
  int   rejected;
  int   cycle_count = 0;
  int   sent        = 0;
  bit   quiet       = 1'b0;
  mix_e mode        = GROW;
  int   fill_est    = 0;

  always #4 clk_i = ~clk_i;

  bounded_array_list_insert_erase #(.DEPTH(LIST_DEPTH)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  bale_list_checker #(.DEPTH(LIST_DEPTH)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .backlog_o    (backlog),
    .checked_o    (checked),
    .rejected_o   (rejected)
  );

  function automatic in_t mk(op_e op, logic [ValueW-1:0] v, int p);
    in_t t;
    t.opcode   = op;
    t.value    = v;
    t.position = PosW'(p);
    return t;
  endfunction

  // random item shaped by a running estimate of the list length
  function automatic in_t next_list_item();
    in_t  t;
    op_e  op;
    int   r;
    int   p;
    logic [ValueW-1:0] v;
    if (mode == GROW && fill_est == LIST_DEPTH) mode = ($urandom_range(0, 1) != 0) ? SHRINK : MIX;
    else if (mode == SHRINK && fill_est == 0) mode = ($urandom_range(0, 1) != 0) ? GROW : MIX;
    else if ($urandom_range(0, 29) == 0) mode = mix_e'($urandom_range(0, 2));
    r = $urandom_range(0, 99);
    case (mode)
      GROW: begin
        if (r < 30) op = OP_PUSH_BACK;
        else if (r < 50) op = OP_PUSH_FRONT;
        else if (r < 75) op = OP_INSERT;
        else if (r < 85) op = OP_READ;
        else if (r < 92) op = OP_WRITE;
        else if (r < 95) op = OP_POP_BACK;
        else if (r < 98) op = OP_POP_FRONT;
        else op = OP_ERASE;
      end
      SHRINK: begin
        if (r < 25) op = OP_POP_BACK;
        else if (r < 45) op = OP_POP_FRONT;
        else if (r < 70) op = OP_ERASE;
        else if (r < 80) op = OP_READ;
        else if (r < 87) op = OP_WRITE;
        else if (r < 92) op = OP_PUSH_BACK;
        else if (r < 96) op = OP_PUSH_FRONT;
        else op = OP_INSERT;
      end
      default: begin
        if (r < 25) op = OP_READ;
        else if (r < 50) op = OP_WRITE;
        else op = op_e'($urandom_range(0, 5));
      end
    endcase
    if ($urandom_range(0, 4) == 0) p = $urandom_range(0, 15);
    else if (op == OP_INSERT) p = $urandom_range(0, (fill_est > 15) ? 15 : fill_est);
    else p = (fill_est > 0) ? $urandom_range(0, fill_est - 1) : 0;
    case ($urandom_range(0, 9))
      0: v = 32'h8000_0000;
      1: v = 32'h7fff_ffff;
      2: v = 32'hffff_ffff;
      3: v = '0;
      default: v = $urandom;
    endcase
    case (op)
      OP_PUSH_BACK, OP_PUSH_FRONT: if (fill_est < LIST_DEPTH) fill_est++;
      OP_INSERT: if (fill_est < LIST_DEPTH && p <= fill_est) fill_est++;
      OP_POP_BACK, OP_POP_FRONT: if (fill_est > 0) fill_est--;
      OP_ERASE: if (p < fill_est) fill_est--;
      default: ;
    endcase
    t = mk(op, v, p);
    return t;
  endfunction

  task automatic send_item(input in_t t);
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk_i); while (!in_ready);
    sent++;
  endtask

  task automatic idle_for(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (backlog != 0);
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: random stalls, one long hold mid-run
  initial begin
    int taken;
    int hold;
    bit long_done;
    taken     = 0;
    hold      = 0;
    long_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid && out_ready) taken++;
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (taken >= LONG_AT && !long_done) begin
        long_done = 1'b1;
        hold      = LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        hold      = $urandom_range(0, 5);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    in_t opening [$];
    int  i;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // rejections on an empty list
    opening.push_back(mk(OP_POP_BACK, '0, 0));
    opening.push_back(mk(OP_POP_FRONT, '0, 0));
    opening.push_back(mk(OP_ERASE, '0, 0));
    opening.push_back(mk(OP_READ, '0, 0));
    opening.push_back(mk(OP_WRITE, 32'h1234_5678, 0));
    opening.push_back(mk(OP_INSERT, 32'd7, 1));
    // fill to capacity with extreme values and every index
    opening.push_back(mk(OP_PUSH_BACK, 32'h8000_0000, 0));
    opening.push_back(mk(OP_PUSH_FRONT, 32'h7fff_ffff, 0));
    opening.push_back(mk(OP_INSERT, '0, 1));
    for (i = 3; i < LIST_DEPTH; i++)
      opening.push_back(mk(OP_INSERT, (i == 15) ? 32'hffff_ffff :
                           (i % 2 != 0) ? 32'h5555_5555 : 32'haaaa_aaaa, i));
    // rejections on a full list
    opening.push_back(mk(OP_PUSH_BACK, 32'd1, 0));
    opening.push_back(mk(OP_PUSH_FRONT, 32'd2, 0));
    opening.push_back(mk(OP_INSERT, 32'd3, 0));
    foreach (opening[k]) send_item(opening[k]);
    fill_est = LIST_DEPTH;
    mode     = SHRINK;

    for (i = 0; i < RAND_ITEMS; i++) begin
      quiet = (i >= RAND_ITEMS - QUIET_TAIL);
      if (i == DRAIN_AT) wait_drained();
      else if (!quiet && $urandom_range(0, 3) == 0) idle_for($urandom_range(1, 6));
      send_item(next_list_item());
    end

    wait_drained();
    repeat (TAIL_WAIT) @(posedge clk_i);
    $display("Sent %0d items; %0d results checked, %0d of them rejected operations.",
             sent, checked, rejected);
    $display("All eight operations ran as the list swept between empty and full.");
    if (fail_count == 0 && backlog == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
